[hw/rtl/sirt_pkg.sv]
// Shared types, constants and helpers of the radix text converter.
// Used by sirt_ctrl, sirt_datapath and signed_int_to_radix_text; no dependencies.
package sirt_pkg;

    localparam int MAX_RADIX_DEF = 64;
    localparam int NUM_W         = 32;
    localparam int CHAR_W        = 8;
    localparam int BASE_W        = 7;
    localparam int DIGIT_SLOTS   = 32;
    localparam int SLOT_AW       = $clog2(DIGIT_SLOTS);
    localparam int NDIG_W        = SLOT_AW + 1;
    localparam int DIV_CNT_W     = $clog2(NUM_W);
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic REG_BASE_LENGTH = 1'b0;

    localparam logic [1:0] OUT_SEL_MINUS = 2'd0;
    localparam logic [1:0] OUT_SEL_DIGIT = 2'd1;
    localparam logic [1:0] OUT_SEL_BAD   = 2'd2;

    typedef struct packed {
        logic       alpha_wr;
        logic       take_num;
        logic       chk_clear;
        logic       chk_rd;
        logic       chk_mark;
        logic       div_start;
        logic       div_step;
        logic       div_store;
        logic       dig_rd;
        logic       sym_rd;
        logic       out_load;
        logic [1:0] out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic range_ok;
        logic sym_bad;
        logic chk_last;
        logic div_last;
        logic quot_zero;
        logic ndig_last;
        logic negative;
        logic ndig_zero;
        logic out_free;
    } dp_status_t;

    function automatic logic is_reserved_char(input logic [CHAR_W-1:0] c);
        return (c == CHAR_NUL) || ((c >= CHAR_TAB) && (c <= CHAR_CR)) ||
               (c == CHAR_SPACE) || (c == CHAR_PLUS) || (c == CHAR_MINUS);
    endfunction

endpackage

[hw/rtl/sirt_ctrl.sv]
// Sequencer of the radix text converter: alphabet check, digit loop, emit.
// Depends on sirt_pkg; drives sirt_datapath through ctrl_cmd_t.
module sirt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 operation,
    output logic                 in_stall,
    input  sirt_pkg::dp_status_t status,
    output sirt_pkg::ctrl_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHK_RD   = 4'd1;
    localparam logic [3:0] S_CHK_TEST = 4'd2;
    localparam logic [3:0] S_DIV      = 4'd3;
    localparam logic [3:0] S_STORE    = 4'd4;
    localparam logic [3:0] S_MINUS    = 4'd5;
    localparam logic [3:0] S_DIG_RD   = 4'd6;
    localparam logic [3:0] S_SYM_RD   = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;
    localparam logic [3:0] S_BAD      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_sel = sirt_pkg::OUT_SEL_DIGIT;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == sirt_pkg::OP_LOAD)
                    begin
                        cmd.alpha_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.take_num  = 1'b1;
                        cmd.chk_clear = 1'b1;
                        state_next    = status.range_ok ? S_CHK_RD : S_BAD;
                    end
                end
            end
            S_CHK_RD:
            begin
                cmd.chk_rd = 1'b1;
                state_next = S_CHK_TEST;
            end
            S_CHK_TEST:
            begin
                if (status.sym_bad)
                begin
                    state_next = S_BAD;
                end
                else
                begin
                    cmd.chk_mark = 1'b1;
                    if (status.chk_last)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_CHK_RD;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.div_store = 1'b1;
                if (!status.quot_zero && !status.ndig_last)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = status.negative ? S_MINUS : S_DIG_RD;
                end
            end
            S_MINUS:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = sirt_pkg::OUT_SEL_MINUS;
                    state_next   = S_DIG_RD;
                end
            end
            S_DIG_RD:
            begin
                cmd.dig_rd = 1'b1;
                state_next = S_SYM_RD;
            end
            S_SYM_RD:
            begin
                cmd.sym_rd = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = sirt_pkg::OUT_SEL_DIGIT;
                    state_next   = status.ndig_zero ? S_IDLE : S_DIG_RD;
                end
            end
            S_BAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = sirt_pkg::OUT_SEL_BAD;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/sirt_datapath.sv]
// Datapath of the radix text converter: alphabet and digit memories, symbol
// check, restoring divider and output register. Depends on sirt_pkg.
module sirt_datapath
#(
    parameter int MAX_RADIX = sirt_pkg::MAX_RADIX_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sirt_pkg::ctrl_cmd_t                 cmd,
    output sirt_pkg::dp_status_t                status,
    input  logic [sirt_pkg::BASE_W-1:0]         base_length,
    input  logic [5:0]                          symbol_index,
    input  logic [sirt_pkg::CHAR_W-1:0]         symbol,
    input  logic signed [sirt_pkg::NUM_W-1:0]   number,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sirt_pkg::CHAR_W-1:0]         character,
    output logic                                base_ok,
    output logic                                last
);

    localparam int AW = $clog2(MAX_RADIX);

    logic [sirt_pkg::CHAR_W-1:0] alpha_mem [MAX_RADIX];
    logic [AW-1:0]               digit_mem [sirt_pkg::DIGIT_SLOTS];

    logic [sirt_pkg::CHAR_W-1:0]    alpha_rdata_reg;
    logic [AW-1:0]                  digit_rdata_reg;
    logic [255:0]                   seen_reg;
    logic [sirt_pkg::BASE_W-1:0]    chk_idx_reg;
    logic [sirt_pkg::NUM_W-1:0]     mag_reg;
    logic [sirt_pkg::NUM_W-1:0]     mag_next;
    logic [sirt_pkg::BASE_W-1:0]    rem_reg;
    logic [sirt_pkg::BASE_W-1:0]    rem_next;
    logic [sirt_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [sirt_pkg::NDIG_W-1:0]    ndig_reg;
    logic [sirt_pkg::NDIG_W-1:0]    ndig_dec;
    logic                           neg_reg;
    logic                           out_valid_reg;
    logic [sirt_pkg::CHAR_W-1:0]    char_reg;
    logic                           base_ok_reg;
    logic                           last_reg;

    logic [sirt_pkg::BASE_W:0]      trial;
    logic                           trial_ge;
    logic [AW-1:0]                  alpha_raddr;
    logic                           out_free;

    assign ndig_dec    = ndig_reg - 1'b1;
    assign out_free    = !out_valid_reg || !out_stall;
    assign alpha_raddr = cmd.chk_rd ? AW'(chk_idx_reg) : digit_rdata_reg;

    assign trial    = {rem_reg, mag_reg[sirt_pkg::NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, base_length});
    assign rem_next = trial_ge ? sirt_pkg::BASE_W'(trial - {1'b0, base_length})
                               : sirt_pkg::BASE_W'(trial);
    assign mag_next = {mag_reg[sirt_pkg::NUM_W-2:0], trial_ge};

    assign status.range_ok  = (base_length >= sirt_pkg::BASE_W'(2)) &&
                              (32'(base_length) <= MAX_RADIX);
    assign status.sym_bad   = sirt_pkg::is_reserved_char(alpha_rdata_reg) ||
                              seen_reg[alpha_rdata_reg];
    assign status.chk_last  = (chk_idx_reg == base_length - 1'b1);
    assign status.div_last  = (div_cnt_reg == '1);
    assign status.quot_zero = (mag_reg == '0);
    assign status.ndig_last = (ndig_reg == sirt_pkg::NDIG_W'(sirt_pkg::DIGIT_SLOTS - 1));
    assign status.negative  = neg_reg;
    assign status.ndig_zero = (ndig_reg == '0);
    assign status.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.alpha_wr && (32'(symbol_index) < MAX_RADIX))
        begin
            alpha_mem[AW'(symbol_index)] <= symbol;
        end
        if (cmd.chk_rd || cmd.sym_rd)
        begin
            alpha_rdata_reg <= alpha_mem[alpha_raddr];
        end
        if (cmd.div_store)
        begin
            digit_mem[ndig_reg[sirt_pkg::SLOT_AW-1:0]] <= AW'(rem_reg);
        end
        if (cmd.dig_rd)
        begin
            digit_rdata_reg <= digit_mem[ndig_dec[sirt_pkg::SLOT_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            chk_idx_reg <= '0;
            mag_reg     <= '0;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            ndig_reg    <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.take_num)
            begin
                neg_reg  <= number[sirt_pkg::NUM_W-1];
                mag_reg  <= number[sirt_pkg::NUM_W-1] ? (32'd0 - unsigned'(number))
                                                      : unsigned'(number);
                ndig_reg <= '0;
            end
            if (cmd.chk_clear)
            begin
                seen_reg    <= '0;
                chk_idx_reg <= '0;
            end
            if (cmd.chk_mark)
            begin
                seen_reg[alpha_rdata_reg] <= 1'b1;
                chk_idx_reg               <= chk_idx_reg + 1'b1;
            end
            if (cmd.div_start)
            begin
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                rem_reg     <= rem_next;
                mag_reg     <= mag_next;
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.div_store)
            begin
                ndig_reg <= ndig_reg + 1'b1;
            end
            if (cmd.dig_rd)
            begin
                ndig_reg <= ndig_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                sirt_pkg::OUT_SEL_MINUS:
                begin
                    char_reg    <= sirt_pkg::CHAR_MINUS;
                    base_ok_reg <= 1'b1;
                    last_reg    <= 1'b0;
                end
                sirt_pkg::OUT_SEL_DIGIT:
                begin
                    char_reg    <= alpha_rdata_reg;
                    base_ok_reg <= 1'b1;
                    last_reg    <= status.ndig_zero;
                end
                default:
                begin
                    char_reg    <= sirt_pkg::CHAR_NUL;
                    base_ok_reg <= 1'b0;
                    last_reg    <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign base_ok   = base_ok_reg;
    assign last      = last_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output beat overwritten before delivery");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_store |-> (rem_reg < base_length))
        else $error("remainder not below radix");

    a_dig_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dig_rd |-> (ndig_reg != '0))
        else $error("digit read from empty buffer");

    a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !base_ok_reg) |-> (last_reg && (char_reg == sirt_pkg::CHAR_NUL)))
        else $error("invalid-alphabet beat malformed");

endmodule

[hw/rtl/signed_int_to_radix_text.sv]
// Top level of the radix text converter: APB register, sequencer, datapath.
// Depends on sirt_pkg, sirt_ctrl and sirt_datapath.
//
// Usage: the input channel (in_valid/in_stall) carries load and convert beats.
// A load beat writes symbol into the alphabet at symbol_index. A convert beat
// checks base_length alphabet entries, reading and then testing each one,
// then divides by the radix once per digit with a bit-serial divider (up to
// 32 digits), then emits a minus sign if negative and the digit symbols most
// significant first, one beat each, with last set on the final beat. A bad
// alphabet or a base_length outside 2..MAX_RADIX yields one beat with
// base_ok low. For a valid alphabet, in_stall stays high through the
// alphabet walk, the digit loop on the shared divider and the emit sequence.
// The output channel (out_valid/out_stall) is registered; a stall holds the
// beat and pauses the emit sequence, while a finished last beat waiting
// downstream does not block the next input beat.
// Reset clears base_length and all control state; the alphabet must be
// loaded before a convert. Write base_length at APB byte address 0 only while
// idle.
module signed_int_to_radix_text
#(
    parameter int MAX_RADIX = sirt_pkg::MAX_RADIX_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sirt_pkg::PADDR_W-1:0]        paddr,
    input  logic [sirt_pkg::PDATA_W-1:0]        pwdata,
    output logic [sirt_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [5:0]                          symbol_index,
    input  logic [sirt_pkg::CHAR_W-1:0]         symbol,
    input  logic signed [sirt_pkg::NUM_W-1:0]   number,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sirt_pkg::CHAR_W-1:0]         character,
    output logic                                base_ok,
    output logic                                last
);

    logic [sirt_pkg::BASE_W-1:0] base_length_reg;
    logic                        reg_sel;
    sirt_pkg::ctrl_cmd_t         cmd;
    sirt_pkg::dp_status_t        status;
    logic                        ctrl_in_valid;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[sirt_pkg::PADDR_W-1] == sirt_pkg::REG_BASE_LENGTH);
    assign prdata  = reg_sel ? sirt_pkg::PDATA_W'(base_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            base_length_reg <= pwdata[sirt_pkg::BASE_W-1:0];
        end
    end

    assign ctrl_in_valid = in_valid;

    sirt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ctrl_in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sirt_datapath #(
        .MAX_RADIX (MAX_RADIX)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .base_length  (base_length_reg),
        .symbol_index (symbol_index),
        .symbol       (symbol),
        .number       (number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .character    (character),
        .base_ok      (base_ok),
        .last         (last)
    );

endmodule
